>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the decoder modules; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> hw/rtl/tdd_pkg.sv
// Types and constants for the tick record delta decoder.
`timescale 1ns / 1ps

package tdd_pkg;

    localparam int PAYLOAD_BITS  = 7;
    localparam int WORD_BITS     = 64;
    localparam int COUNT_BITS    = 32;
    localparam int POS_BITS      = 4;
    localparam int SHAMT_BITS    = 6;
    localparam logic [POS_BITS-1:0] LAST_BYTE_POS = 4'd9;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       section_end;
    } src_item_t;

    typedef struct packed {
        logic                        status;
        logic signed [WORD_BITS-1:0] timestamp;
        logic signed [WORD_BITS-1:0] price;
        logic [WORD_BITS-1:0]        quantity;
        logic                        final_record;
    } rec_item_t;

    // Which varint of the record is being gathered
    typedef enum logic [2:0] {
        FLD_TS    = 3'b001,
        FLD_PRICE = 3'b010,
        FLD_QTY   = 3'b100
    } field_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_TS    = 2'd1,
        EV_PRICE = 2'd2,
        EV_QTY   = 2'd3
    } ev_kind_t;

    // One completed varint (or a bare corruption) handed from front to back
    typedef struct packed {
        ev_kind_t             kind;
        logic                 corrupt;
        logic                 final_rec;
        logic [WORD_BITS-1:0] value;
    } event_t;

    typedef struct packed {
        logic push;
        logic full;
    } q_ctl_t;

endpackage

>>> hw/rtl/tdd_queue.sv
// Short event queue between the decoder front and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdd_queue
    import tdd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  event_t push_ev,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output event_t head_ev
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    event_t          fifo_reg [DEPTH];
    logic [AW-1:0]   wptr_reg, wptr_next;
    logic [AW-1:0]   rptr_reg, rptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_ev    = fifo_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_reg[wptr_reg] <= push_ev;
        end
    end

    // Front must hold off while the queue is full, otherwise an event is lost
    `ASSERT_IMPLIES(a_no_push_when_full, full, !push)

endmodule

>>> hw/rtl/tdd_front.sv
// Decoder front: accepts bytes, gathers varints and classifies completed fields.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdd_front
    import tdd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  src_item_t             src_item,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    input  logic                  q_full,
    output q_ctl_t                q_ctl,
    output event_t                q_ev
);

    logic [COUNT_BITS-1:0] count_cfg_reg;
    logic [COUNT_BITS-1:0] done_reg, done_next;
    field_t                field_reg, field_next;
    logic [WORD_BITS-1:0]  acc_reg, acc_next;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic                  err_reg, err_next;

    logic                  accept;
    logic                  active;
    logic [SHAMT_BITS-1:0] shamt;
    logic [WORD_BITS-1:0]  acc_or;
    logic [COUNT_BITS-1:0] done_inc;
    logic                  push;
    event_t                ev;

    assign src_stall = q_full;
    assign accept    = src_valid && !src_stall;
    assign active    = !err_reg && (done_reg < count_cfg_reg);
    assign shamt     = SHAMT_BITS'(PAYLOAD_BITS * pos_reg);
    assign acc_or    = acc_reg | (WORD_BITS'(src_item.data_byte[PAYLOAD_BITS-1:0]) << shamt);
    assign done_inc  = done_reg + 1'b1;

    always_comb
    begin
        field_next   = field_reg;
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        err_next     = err_reg;
        done_next    = done_reg;
        push         = 1'b0;
        ev.kind      = EV_NONE;
        ev.corrupt   = 1'b0;
        ev.final_rec = 1'b0;
        ev.value     = acc_or;

        if (accept && active)
        begin
            if (src_item.data_byte[PAYLOAD_BITS])
            begin
                if (pos_reg == LAST_BYTE_POS || src_item.section_end)
                begin
                    // overlong or cut off mid-varint
                    push       = 1'b1;
                    ev.corrupt = 1'b1;
                    err_next   = 1'b1;
                    field_next = FLD_TS;
                    acc_next   = '0;
                    pos_next   = '0;
                end
                else
                begin
                    acc_next = acc_or;
                    pos_next = pos_reg + 1'b1;
                end
            end
            else
            begin
                acc_next = '0;
                pos_next = '0;
                push     = 1'b1;
                unique case (field_reg)
                    FLD_TS:
                    begin
                        ev.kind    = EV_TS;
                        ev.corrupt = src_item.section_end;
                        field_next = src_item.section_end ? FLD_TS : FLD_PRICE;
                        err_next   = src_item.section_end;
                    end
                    FLD_PRICE:
                    begin
                        ev.kind    = EV_PRICE;
                        ev.corrupt = src_item.section_end;
                        field_next = src_item.section_end ? FLD_TS : FLD_QTY;
                        err_next   = src_item.section_end;
                    end
                    default:
                    begin
                        ev.kind      = EV_QTY;
                        ev.final_rec = (done_inc == count_cfg_reg);
                        field_next   = FLD_TS;
                        done_next    = done_inc;
                    end
                endcase
            end
        end
    end

    assign q_ctl.push = push;
    assign q_ctl.full = q_full;
    assign q_ev       = ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= '0;
            done_reg      <= '0;
            field_reg     <= FLD_TS;
            acc_reg       <= '0;
            pos_reg       <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_cfg_reg <= cfg_wdata;
            end
            done_reg  <= done_next;
            field_reg <= field_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

    // Error latch holds until reset
    `ASSERT_NEXT(a_err_sticky, err_reg, err_reg)
    `ASSERT_ALWAYS(a_pos_in_range, pos_reg <= LAST_BYTE_POS)

endmodule

>>> hw/rtl/tdd_back.sv
// Decoder back: applies deltas to the running sums and registers the results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tdd_back
    import tdd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  event_t    head_ev,
    output logic      pop,
    output logic      rec_valid,
    input  logic      rec_stall,
    output rec_item_t rec_item
);

    logic [WORD_BITS-1:0] ts_reg, ts_next;
    logic [WORD_BITS-1:0] price_reg, price_next;
    logic                 out_valid_reg, out_valid_next;
    rec_item_t            out_reg;

    logic                 needs_result;
    logic                 out_free;
    logic [WORD_BITS-1:0] zigzag;
    logic [WORD_BITS-1:0] ts_add, price_add;

    assign needs_result = head_ev.corrupt || (head_ev.kind == EV_QTY);
    assign out_free     = !out_valid_reg || !rec_stall;
    // Deltas without a result never wait on the output side
    assign pop          = head_valid && (!needs_result || out_free);

    assign zigzag    = (head_ev.value >> 1) ^ {WORD_BITS{head_ev.value[0]}};
    assign ts_add    = (head_ev.kind == EV_TS)    ? head_ev.value : '0;
    assign price_add = (head_ev.kind == EV_PRICE) ? zigzag        : '0;

    always_comb
    begin
        ts_next        = ts_reg;
        price_next     = price_reg;
        out_valid_next = out_valid_reg && rec_stall;
        if (pop)
        begin
            ts_next    = ts_reg + ts_add;
            price_next = price_reg + price_add;
            if (needs_result)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ts_reg        <= '0;
            price_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ts_reg        <= ts_next;
            price_reg     <= price_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && needs_result)
        begin
            out_reg.status       <= head_ev.corrupt;
            out_reg.timestamp    <= ts_next;
            out_reg.price        <= price_next;
            out_reg.quantity     <= head_ev.corrupt ? '0 : head_ev.value;
            out_reg.final_record <= head_ev.final_rec && !head_ev.corrupt;
        end
    end

    assign rec_valid = out_valid_reg;
    assign rec_item  = out_reg;

    `ASSERT_IMPLIES(a_corrupt_fields, out_valid_reg && out_reg.status,
                    out_reg.quantity == '0 && !out_reg.final_record)

endmodule

>>> hw/rtl/tick_record_delta_decoder_top.sv
// Tick record delta decoder top level: byte front, event queue, summing back.
// A byte that completes a record or a corruption is queued, then registered in the back's output.
// Throughput: one byte per cycle unless the queue is full, set by the varint gather in the front.
// Back pops one event a cycle unless a result is stalled; queue absorbs that before bytes are held.
// Reset (rst_n, asynchronous, active low) clears all sums, counts, the error latch and record limit.
`timescale 1ns / 1ps

module tick_record_delta_decoder_top
    import tdd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    output logic                  src_stall,
    input  src_item_t             src_item,
    output logic                  rec_valid,
    input  logic                  rec_stall,
    output rec_item_t             rec_item,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata
);

    q_ctl_t q_ctl;
    event_t q_ev;
    event_t head_ev;
    logic   q_full;
    logic   head_valid;
    logic   pop;

    tdd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_ctl     (q_ctl),
        .q_ev      (q_ev)
    );

    tdd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_ctl.push),
        .push_ev    (q_ev),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_ev    (head_ev)
    );

    tdd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ev    (head_ev),
        .pop        (pop),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_item   (rec_item)
    );

endmodule

>>> dv/tick_record_checker.sv
// Checker for the tick record decoder: predicts decoded records and compares them.
`timescale 1ns / 1ps

module tick_record_checker
    import tdd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  src_valid,
    input  logic                  src_stall,
    input  src_item_t             src_item,
    input  logic                  rec_valid,
    input  logic                  rec_stall,
    input  rec_item_t             rec_item,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    // Decoder state as predicted
    field_t                fld        = FLD_TS;
    logic [WORD_BITS-1:0]  acc        = '0;
    logic [POS_BITS-1:0]   pos        = '0;
    logic [WORD_BITS-1:0]  ts_sum     = '0;
    logic [WORD_BITS-1:0]  px_sum     = '0;
    logic [COUNT_BITS-1:0] done_cnt   = '0;
    logic [COUNT_BITS-1:0] rec_limit  = '0;
    logic                  err_seen   = 1'b0;

    rec_item_t expected_records[$];
    int        mismatches = 0;

    function automatic void note_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endfunction

    function automatic void flag_corrupt();
        rec_item_t r;
        err_seen = 1'b1;
        fld = FLD_TS;
        acc = '0;
        pos = '0;
        r.status       = 1'b1;
        r.timestamp    = ts_sum;
        r.price        = px_sum;
        r.quantity     = '0;
        r.final_record = 1'b0;
        expected_records.push_back(r);
    endfunction

    function automatic void decode_byte(input src_item_t it);
        logic [WORD_BITS-1:0] word;
        rec_item_t            r;
        if (err_seen || done_cnt >= rec_limit)
            return;
        if (pos > LAST_BYTE_POS)
            pos = LAST_BYTE_POS;
        // payload bits shifted past bit 63 fall away here
        acc |= {57'd0, it.data_byte[6:0]} << (PAYLOAD_BITS * pos);
        if (it.data_byte[7])
        begin
            if (pos == LAST_BYTE_POS || it.section_end)
                flag_corrupt();
            else
                pos++;
            return;
        end
        word = acc;
        acc  = '0;
        pos  = '0;
        case (fld)
            FLD_TS:
            begin
                ts_sum += word;
                fld = FLD_PRICE;
                if (it.section_end)
                    flag_corrupt();
            end
            FLD_PRICE:
            begin
                // undo the zigzag mapping
                px_sum += (word >> 1) ^ {WORD_BITS{word[0]}};
                fld = FLD_QTY;
                if (it.section_end)
                    flag_corrupt();
            end
            default:
            begin
                fld = FLD_TS;
                done_cnt++;
                r.status       = 1'b0;
                r.timestamp    = ts_sum;
                r.price        = px_sum;
                r.quantity     = word;
                r.final_record = (done_cnt == rec_limit);
                expected_records.push_back(r);
            end
        endcase
    endfunction

    function automatic void check_record(input rec_item_t got);
        rec_item_t want;
        if (expected_records.size() == 0)
        begin
            note_mismatch("record with none outstanding, timestamp", 64'd0, got.timestamp);
            return;
        end
        want = expected_records.pop_front();
        if (got.status !== want.status)
            note_mismatch("status", 64'(want.status), 64'(got.status));
        if (got.timestamp !== want.timestamp)
            note_mismatch("timestamp", want.timestamp, got.timestamp);
        if (got.price !== want.price)
            note_mismatch("price", want.price, got.price);
        if (got.quantity !== want.quantity)
            note_mismatch("quantity", want.quantity, got.quantity);
        if (got.final_record !== want.final_record)
            note_mismatch("final_record", 64'(want.final_record), 64'(got.final_record));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fld       = FLD_TS;
            acc       = '0;
            pos       = '0;
            ts_sum    = '0;
            px_sum    = '0;
            done_cnt  = '0;
            rec_limit = '0;
            err_seen  = 1'b0;
            expected_records.delete();
        end
        else
        begin
            if (cfg_we)
                rec_limit = cfg_wdata;
            if (src_valid && !src_stall)
                decode_byte(src_item);
            if (rec_valid && !rec_stall)
                check_record(rec_item);
        end
        pending    = expected_records.size();
        fail_count = mismatches;
    end

endmodule

>>> dv/testbench.sv
// Top of the tick record decoder testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import tdd_pkg::*;

    typedef enum int {
        BREAK_OVERLONG,
        BREAK_CUT_MID,
        BREAK_CUT_FIELD
    } break_kind_t;

    logic                  clk;
    logic                  rst_n;
    logic                  src_valid;
    logic                  src_stall;
    src_item_t             src_item;
    logic                  rec_valid;
    logic                  rec_stall;
    rec_item_t             rec_item;
    logic                  cfg_we;
    logic [COUNT_BITS-1:0] cfg_wdata;

    int fail_count;
    int pending;

    int src_idle        = 0;
    int rec_hold_pct    = 0;
    int hold_left       = 0;
    int bytes_sent      = 0;
    int records_decoded = 0;

    tick_record_delta_decoder_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_item  (rec_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tick_record_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_item   (src_item),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_item   (rec_item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("testbench failed");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        rec_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rec_stall <= 1'b1;
                hold_left--;
            end
            else
                rec_stall <= ($urandom_range(0, 99) < rec_hold_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= {b, last};
        do
            @(posedge clk);
        while (src_stall);
        @(negedge clk);
        bytes_sent++;
    endtask

    // Mostly short varints, now and then up to the full ten bytes
    function automatic int varint_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(1, 3);
        return $urandom_range(4, 10);
    endfunction

    task automatic send_varint(input int nbytes, input logic end_flag);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++)
        begin
            case ($urandom_range(0, 3))
                0:       b = 8'h7F;
                1:       b = 8'h00;
                default: b = 8'($urandom_range(0, 127));
            endcase
            b[7] = (i != nbytes - 1);
            send_byte(b, end_flag && (i == nbytes - 1));
        end
    endtask

    task automatic send_record(input logic end_flag);
        send_varint(varint_len(), 1'b0);
        send_varint(varint_len(), 1'b0);
        send_varint(varint_len(), end_flag);
    endtask

    // Hold the sender until every record is out, then let the pipe settle
    task automatic drain();
        src_valid <= 1'b0;
        wait (pending == 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_count(input logic [COUNT_BITS-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int          idle_tab[4];
        int          stall_tab[4];
        int          first;
        int          n;
        int          lead;
        break_kind_t kind;
        logic [7:0]  b;

        idle_tab  = '{0, 59, 0, 31};
        stall_tab = '{0, 0, 59, 31};
        rst_n     = 1'b0;
        src_valid = 1'b0;
        src_item  = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Count of zero: everything dropped, even a would-be corruption
        write_count('0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        drain();

        write_count(32'd3);
        // all-zero record
        repeat (3) send_byte(8'h00, 1'b0);
        // ten-byte timestamp of all ones, high payload bits dropped; price -64
        repeat (9) send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h7F, 1'b0);
        // padded timestamp, price +1, clean section end on the last record
        send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        // count reached: drop this record
        repeat (3) send_byte(8'h00, 1'b0);
        records_decoded = 3;
        drain();

        write_count('1);
        for (int p = 0; p < 4; p++)
        begin
            src_idle     = idle_tab[p];
            rec_hold_pct = stall_tab[p];
            first        = bytes_sent;
            n            = 0;
            while (bytes_sent - first < 150)
            begin
                // hold results back long enough to back up the input
                if (p == 0 && n == 5)
                    hold_left = 80;
                if (p == 0 && n == 20)
                    drain();
                send_record($urandom_range(0, 7) == 0);
                n++;
                records_decoded++;
            end
        end
        drain();

        // resume, reach the new count part-way through
        write_count(records_decoded + 5);
        repeat (8) send_record($urandom_range(0, 7) == 0);
        records_decoded += 5;
        drain();

        // count below what is already done: nothing decoded
        write_count(32'd1);
        repeat (2) send_record(1'b0);
        drain();

        write_count('1);
        repeat (3) send_record($urandom_range(0, 3) == 0);
        kind = break_kind_t'($urandom_range(0, 2));
        lead = (kind == BREAK_CUT_FIELD) ? $urandom_range(0, 1) : $urandom_range(0, 2);
        repeat (lead) send_varint(varint_len(), 1'b0);
        case (kind)
            BREAK_OVERLONG:
            begin
                repeat (10)
                begin
                    b = 8'($urandom_range(0, 127));
                    send_byte(b | 8'h80, 1'b0);
                end
            end
            BREAK_CUT_MID:
            begin
                n = $urandom_range(1, 9);
                for (int i = 0; i < n; i++)
                begin
                    b = 8'($urandom_range(0, 127));
                    send_byte(b | 8'h80, i == n - 1);
                end
            end
            default:
                send_varint(varint_len(), 1'b1);
        endcase
        // error latched: drop these
        repeat (4)
        begin
            b = 8'($urandom_range(0, 255));
            send_byte(b, 1'($urandom_range(0, 1)));
        end
        src_valid <= 1'b0;

        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/tdd_pkg.sv
hw/rtl/tdd_queue.sv
hw/rtl/tdd_front.sv
hw/rtl/tdd_back.sv
hw/rtl/tick_record_delta_decoder_top.sv
dv/tick_record_checker.sv
dv/testbench.sv
